// File: rtl/core/dva_pkg.sv
// Package for the drum voice allocator: sizes, codes, payload structs.
// No dependencies.
package dva_pkg;

  localparam int VOICES = 16;
  localparam int PADS   = 16;
  localparam int VW     = $clog2(VOICES);
  localparam int PW     = 5;
  localparam logic [PW-1:0] NO_PAD = 5'd31;
  localparam logic [16:0] GAIN_ONE = 17'd65536;

  // Per-voice record: active, owner, pos, level, mult, fading, ignored.
  localparam int REC_W = 1 + PW + 16 + 15 + 17 + 1 + 1;

  typedef enum logic [2:0] {
    MODE_ALLOC    = 3'd0,
    MODE_TICK     = 3'd1,
    MODE_FINISH   = 3'd2,
    MODE_STOP_PAD = 3'd3,
    MODE_FADE_ON  = 3'd4,
    MODE_FADE_OFF = 3'd5,
    MODE_FADE_STEP = 3'd6,
    MODE_NONE     = 3'd7
  } mode_t;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_GAIN   = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;

  localparam logic [1:0] CFG_STEAL_MIN = 2'd0;
  localparam logic [1:0] CFG_FLOOR     = 2'd1;
  localparam logic [1:0] CFG_LIMIT     = 2'd2;

  typedef struct packed {
    logic        active;
    logic [PW-1:0] owner;
    logic [15:0] pos;
    logic [14:0] level;
    logic [16:0] mult;
    logic        fading;
    logic        ignored;
  } voice_rec_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  pad;
    logic [14:0] level;
    logic        no_fade;
    logic [16:0] fade_gain;
    logic [3:0]  voice_id;
  } req_t;

  typedef struct packed {
    logic [3:0]  voice;
    logic [1:0]  kind;
    logic [14:0] gain_out;
    logic        stolen;
    logic        last;
  } res_t;

endpackage

// File: rtl/core/dva_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module dva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/drum_voice_allocator.sv
// Drum voice allocator top level: sequencer over a voice record RAM.
// Depends on dva_pkg and dva_ram.
// After reset a clearing pass writes every record.
// A request holds the block from acceptance to the next ready; an allocate runs a
// scan, a pick of one pad a cycle and a write pass; every released result stalls
// the pass until it is taken.
// Reset is synchronous and active high; registers return to 2, 4 and 20480.
module drum_voice_allocator (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dva_pkg::req_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dva_pkg::res_t    out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [14:0]      cfg_data
);
  localparam int VW = dva_pkg::VW;
  localparam int PN = dva_pkg::PADS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_PICK, S_PASS, S_EMIT, S_DONE
  } state_t;

  state_t state;
  logic [4:0]  steal_min;
  logic [14:0] floor_lvl, limit_lvl;
  dva_pkg::req_t req;

  // RAM
  logic we;
  logic [VW-1:0] waddr, raddr;
  dva_pkg::voice_rec_t wrec, rrec;
  logic [dva_pkg::REC_W-1:0] rdata;
  assign rrec = dva_pkg::voice_rec_t'(rdata);

  dva_ram #(.WIDTH(dva_pkg::REC_W), .DEPTH(dva_pkg::VOICES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wrec), .raddr(raddr), .rdata(rdata)
  );

  // scan bookkeeping
  logic [VW:0]   ridx;     // next read address, may reach VOICES
  logic          rvalid;   // rdata belongs to cur
  logic [VW-1:0] cur;
  logic          have_free;
  logic [VW-1:0] free_v;
  logic [VW:0]   cnt   [PN];
  logic [VW-1:0] old_v [PN];
  logic [15:0]   old_p [PN];
  logic [VW-1:0] qui_v [PN];
  logic [14:0]   qui_l [PN];
  logic [4:0]    pscan;     // pad index for pick pass
  logic          found1;
  logic [VW-1:0] pick1;
  logic [VW:0]   bestc;
  logic [VW-1:0] bestv;
  logic [VW-1:0] target;
  logic          stolen_f;
  logic          pend_v;
  dva_pkg::res_t pend;
  logic          hold_v;    // newest result, released once a later one or the end shows up
  dva_pkg::res_t hold;
  dva_pkg::res_t hold_fin;
  logic          lastpass;
  logic          stall;

  assign in_ready = (state == S_IDLE);

  // pass-stage record update
  dva_pkg::voice_rec_t nrec;
  logic          emit;
  dva_pkg::res_t eres;
  logic [31:0]   prod;
  logic [16:0]   nl;
  logic [4:0]    need;
  logic          hit;

  assign need = (steal_min == 5'd0) ? 5'd1 : steal_min;
  assign prod = {17'd0, rrec.level} * {15'd0, rrec.mult};
  assign nl   = prod[32-1:16] > 16'h7FFF ? 17'h7FFF : {1'b0, prod[31:16]};

  always_comb begin
    nrec = rrec;
    emit = 1'b0;
    eres = '0;
    eres.voice = 4'(cur);
    hit = rrec.active && (rrec.owner == {1'b0, req.pad});
    case (dva_pkg::mode_t'(req.mode))
      dva_pkg::MODE_ALLOC: begin
        if (cur == target) begin
          nrec.active = 1'b1;
          nrec.owner = {1'b0, req.pad};
          nrec.pos = '0;
          nrec.level = (req.level > limit_lvl) ? limit_lvl : req.level;
          nrec.mult = dva_pkg::GAIN_ONE;
          nrec.fading = 1'b0;
          nrec.ignored = req.no_fade;
          emit = 1'b1;
          eres.kind = dva_pkg::KIND_START;
          eres.gain_out = nrec.level;
          eres.stolen = stolen_f;
        end
      end
      dva_pkg::MODE_TICK:
        if (rrec.active && rrec.pos != 16'hFFFF) nrec.pos = rrec.pos + 16'd1;
      dva_pkg::MODE_FINISH:
        if ({1'b0, req.voice_id} < (VW+1)'(dva_pkg::VOICES) &&
            cur == VW'(req.voice_id) && rrec.active) begin
          nrec.active = 1'b0;
          nrec.fading = 1'b0;
          emit = 1'b1;
          eres.kind = dva_pkg::KIND_STOP;
        end
      dva_pkg::MODE_STOP_PAD:
        if (hit) begin
          nrec.active = 1'b0;
          nrec.owner = dva_pkg::NO_PAD;
          nrec.fading = 1'b0;
          emit = 1'b1;
          eres.kind = dva_pkg::KIND_STOP;
        end
      dva_pkg::MODE_FADE_ON:
        if (hit && !rrec.ignored) begin
          if (req.fade_gain < dva_pkg::GAIN_ONE) begin
            nrec.fading = 1'b1;
            if (req.fade_gain < rrec.mult) nrec.mult = req.fade_gain;
          end else begin
            nrec.fading = 1'b0;
            nrec.mult = dva_pkg::GAIN_ONE;
          end
        end
      dva_pkg::MODE_FADE_OFF:
        if (hit) begin
          nrec.fading = 1'b0;
          nrec.mult = dva_pkg::GAIN_ONE;
        end
      dva_pkg::MODE_FADE_STEP:
        if (hit && rrec.fading) begin
          nrec.level = nl[14:0];
          emit = 1'b1;
          eres.gain_out = nl[14:0];
          if (nl[14:0] <= floor_lvl) begin
            nrec.active = 1'b0;
            nrec.owner = dva_pkg::NO_PAD;
            nrec.fading = 1'b0;
            eres.kind = dva_pkg::KIND_STOP;
          end else begin
            eres.kind = dva_pkg::KIND_GAIN;
          end
        end
      default: ;
    endcase
  end

  // final result of a request carries the last mark
  always_comb begin
    hold_fin = hold;
    hold_fin.last = 1'b1;
  end

  // pass waits while the output register is full; re-read cur meanwhile
  assign stall = (state == S_PASS) && rvalid && pend_v;

  // write port: clearing pass or pass-stage write-back
  always_comb begin
    we = 1'b0;
    waddr = cur;
    wrec = nrec;
    raddr = stall ? cur : ridx[VW-1:0];
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = ridx[VW-1:0];
      wrec = '{active: 1'b0, owner: dva_pkg::NO_PAD, pos: 16'd0, level: 15'd0,
               mult: dva_pkg::GAIN_ONE, fading: 1'b0, ignored: 1'b0};
    end else if (state == S_PASS && rvalid && !pend_v) begin
      we = 1'b1;
    end
  end

  logic [VW-1:0] pv;
  assign pv = rrec.owner[VW-1:0];
  assign out_valid = pend_v;
  assign out_data = pend;
  assign lastpass = (ridx == (VW+1)'(dva_pkg::VOICES));

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      steal_min <= 5'd2;
      floor_lvl <= 15'd4;
      limit_lvl <= 15'd20480;
    end else if (cfg_we) begin
      case (cfg_index)
        dva_pkg::CFG_STEAL_MIN: steal_min <= cfg_data[4:0];
        dva_pkg::CFG_FLOOR:     floor_lvl <= cfg_data;
        dva_pkg::CFG_LIMIT:     limit_lvl <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ridx <= '0;
      rvalid <= 1'b0;
      pend_v <= 1'b0;
      hold_v <= 1'b0;
    end else begin
      if (pend_v && out_ready) pend_v <= 1'b0;
      case (state)
        S_CLEAR: begin
          ridx <= ridx + 1'b1;
          if (ridx[VW-1:0] == VW'(dva_pkg::VOICES - 1)) begin
            state <= S_IDLE;
            ridx <= '0;
          end
        end
        S_IDLE: if (in_valid) begin
          req <= in_data;
          ridx <= '0;
          rvalid <= 1'b0;
          stolen_f <= 1'b0;
          target <= '0;
          if (in_data.mode == dva_pkg::MODE_ALLOC) begin
            state <= S_SCAN;
            have_free <= 1'b0;
            for (int p = 0; p < PN; p++) cnt[p] <= '0;
          end else if (in_data.mode == dva_pkg::MODE_NONE) begin
            state <= S_IDLE;
          end else begin
            state <= S_PASS;
          end
        end
        S_SCAN: begin
          // one record a cycle: find free voice, per-pad oldest/quietest
          if (!lastpass) ridx <= ridx + 1'b1;
          rvalid <= !lastpass;
          cur <= ridx[VW-1:0];
          if (rvalid) begin
            if (!rrec.active && !have_free) begin
              have_free <= 1'b1;
              free_v <= cur;
            end
            if (rrec.owner < dva_pkg::PW'(PN)) begin
              cnt[pv] <= cnt[pv] + 1'b1;
              if (cnt[pv] == '0 || rrec.pos > old_p[pv]) begin
                old_v[pv] <= cur; old_p[pv] <= rrec.pos;
              end
              if (cnt[pv] == '0 || rrec.level < qui_l[pv]) begin
                qui_v[pv] <= cur; qui_l[pv] <= rrec.level;
              end
            end
          end
          if (!rvalid && lastpass) begin
            state <= S_PICK;
            pscan <= '0;
            found1 <= 1'b0;
            bestc <= '0;
            bestv <= '0;
          end
        end
        S_PICK: begin
          // one pad a cycle
          if (pscan < 5'(PN)) begin
            if (!found1 && cnt[pscan[VW-1:0]] >= (VW+1)'(need) && cnt[pscan[VW-1:0]] != '0 &&
                qui_v[pscan[VW-1:0]] == old_v[pscan[VW-1:0]]) begin
              found1 <= 1'b1;
              pick1 <= old_v[pscan[VW-1:0]];
            end
            if (cnt[pscan[VW-1:0]] > bestc) begin
              bestc <= cnt[pscan[VW-1:0]];
              bestv <= old_v[pscan[VW-1:0]];
            end
            pscan <= pscan + 5'd1;
          end else begin
            if (have_free) target <= free_v;
            else begin
              stolen_f <= 1'b1;
              target <= found1 ? pick1 : (bestc != '0 ? bestv : '0);
            end
            state <= S_PASS;
            ridx <= '0;
            rvalid <= 1'b0;
          end
        end
        S_PASS: begin
          // read, modify, write back one voice; stall while a result waits
          if (!stall) begin
            if (!lastpass) ridx <= ridx + 1'b1;
            rvalid <= !lastpass;
            cur <= ridx[VW-1:0];
            if (rvalid && emit) begin
              // a later result exists, so the held one is not the final one
              if (hold_v) begin
                pend <= hold;
                pend_v <= 1'b1;
              end
              hold <= eres;
              hold_v <= 1'b1;
            end
            if (!rvalid && lastpass) state <= S_DONE;
          end
        end
        S_DONE: begin
          // release the final result once the output register is free
          if (!pend_v) begin
            if (hold_v) begin
              pend <= hold_fin;
              pend_v <= 1'b1;
            end
            hold_v <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
